>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the PID block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> rtl/pidpi_pkg.sv
// Package with widths, register indexes and the configuration type of the PID block.
`default_nettype none

package pidpi_pkg;

    localparam int MEAS_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int INTEGRAL_LIMIT_DEF = 7000;
    localparam int FRAC_BITS_DEF      = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_MODE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [MEAS_W-1:0] setpoint;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic                     incremental_mode;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/pidpi_cfg.sv
// Configuration register file of the PID block.
`default_nettype none

module pidpi_cfg
    import pidpi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SETPOINT: cfg_next.setpoint         = $signed(cfg_data);
                CFG_GAIN_P:   cfg_next.gain_p           = $signed(cfg_data);
                CFG_GAIN_I:   cfg_next.gain_i           = $signed(cfg_data);
                CFG_GAIN_D:   cfg_next.gain_d           = $signed(cfg_data);
                CFG_MODE:     cfg_next.incremental_mode = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidpi_core.sv
// PID datapath: error terms, clamped integral, gain products and saturated drive.
`default_nettype none
`include "assert_macros.svh"

module pidpi_core
    import pidpi_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic signed [MEAS_W-1:0] meas,
    input  wire cfg_t                     cfg,
    output logic signed [DRIVE_W-1:0]     drive
);

    localparam int E_W  = MEAS_W + 1;
    localparam int D1_W = E_W + 1;
    localparam int D2_W = E_W + 2;
    localparam int ISW  = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int IW   = ((ISW > E_W) ? ISW : E_W) + 1;
    localparam int P_W  = GAIN_W + D2_W;
    localparam int SW   = P_W + 2;
    localparam int AW   = SW + 1;

    localparam logic signed [IW-1:0]  LIM_POS   = IW'(INTEGRAL_LIMIT);
    localparam logic signed [IW-1:0]  LIM_NEG   = -LIM_POS;
    localparam logic signed [ISW-1:0] LIM_STORE = ISW'(INTEGRAL_LIMIT);
    localparam logic signed [AW-1:0]  DRV_MAX   = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0]  DRV_MIN   = AW'(-64'sd2147483648);

    logic signed [ISW-1:0]     error_sum_reg;
    logic signed [ISW-1:0]     error_sum_next;
    logic signed [E_W-1:0]     prev_error_reg;
    logic signed [E_W-1:0]     prev_prev_error_reg;
    logic signed [DRIVE_W-1:0] drive_acc_reg;
    logic signed [DRIVE_W-1:0] drive_acc_next;

    logic signed [E_W-1:0]          err;
    logic signed [D1_W-1:0]         d1;
    logic signed [D2_W-1:0]         d2;
    logic signed [IW-1:0]           integ_raw;
    logic signed [IW-1:0]           integ_clamped;
    logic signed [D1_W-1:0]         op_p;
    logic signed [D1_W-1:0]         op_i;
    logic signed [D2_W-1:0]         op_d;
    logic signed [GAIN_W+D1_W-1:0]  prod_p;
    logic signed [GAIN_W+D1_W-1:0]  prod_i;
    logic signed [P_W-1:0]          prod_d;
    logic signed [SW-1:0]           sum;
    logic signed [SW-1:0]           sum_shifted;
    logic signed [AW-1:0]           acc_sum;

    assign err = E_W'(cfg.setpoint) - E_W'(meas);
    assign d1  = D1_W'(err) - D1_W'(prev_error_reg);
    assign d2  = D2_W'(err) - (D2_W'(prev_error_reg) <<< 1) + D2_W'(prev_prev_error_reg);

    // Integral is formed at full width and then clamped to the symmetric limit.
    assign integ_raw = IW'(error_sum_reg) + IW'(err);

    always_comb
    begin
        if (integ_raw > LIM_POS)
        begin
            integ_clamped = LIM_POS;
        end
        else if (integ_raw < LIM_NEG)
        begin
            integ_clamped = LIM_NEG;
        end
        else
        begin
            integ_clamped = integ_raw;
        end
    end

    // The three multipliers are shared by both forms; only their operands change.
    assign op_p = cfg.incremental_mode ? d1 : D1_W'(err);
    assign op_i = cfg.incremental_mode ? D1_W'(err) : D1_W'(integ_clamped);
    assign op_d = cfg.incremental_mode ? d2 : D2_W'(d1);

    assign prod_p = cfg.gain_p * op_p;
    assign prod_i = cfg.gain_i * op_i;
    assign prod_d = cfg.gain_d * op_d;

    assign sum         = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
    assign sum_shifted = sum >>> FRAC_BITS;

    assign acc_sum = cfg.incremental_mode ? (AW'(drive_acc_reg) + AW'(sum_shifted))
                                          : AW'(sum_shifted);

    always_comb
    begin
        if (acc_sum > DRV_MAX)
        begin
            drive_acc_next = DRIVE_W'(DRV_MAX);
        end
        else if (acc_sum < DRV_MIN)
        begin
            drive_acc_next = DRIVE_W'(DRV_MIN);
        end
        else
        begin
            drive_acc_next = DRIVE_W'(acc_sum);
        end
    end

    assign error_sum_next = ISW'(integ_clamped);
    assign drive          = drive_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg       <= '0;
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            drive_acc_reg       <= '0;
        end
        else if (step)
        begin
            if (cfg.incremental_mode)
            begin
                prev_prev_error_reg <= prev_error_reg;
            end
            else
            begin
                error_sum_reg <= error_sum_next;
            end
            prev_error_reg <= err;
            drive_acc_reg  <= drive_acc_next;
        end
    end

    `ASSERT_NEVER(a_integral_in_range, clk, rst_n,
        (error_sum_reg > LIM_STORE) || (error_sum_reg < -LIM_STORE))
    `ASSERT_PROP(a_incr_shifts_history, clk, rst_n,
        (step && cfg.incremental_mode) |=> (prev_prev_error_reg == $past(prev_error_reg)))
    `ASSERT_PROP(a_pos_keeps_history, clk, rst_n,
        (step && !cfg.incremental_mode) |=> $stable(prev_prev_error_reg))

endmodule

`default_nettype wire

>>> rtl/pid_positional_incremental.sv
// Top level of the PID controller with positional and incremental forms.
//
// Usage: one measured sample is transferred on the input channel (in_valid,
// in_stall, measurement) per control tick, and exactly one drive value comes
// back on the output channel (out_valid, out_stall, drive) for each sample,
// in order. A transfer happens at a rising edge with valid high and stall low.
// The sample lands in an input register; once the output register can take a
// new value, the full controller update (error, clamped integral, three gain
// products, shift and saturation) is done in a single pass and lands in the
// drive register, which is also the output register, and out_valid rises.
// Throughput is one sample per cycle while the receiver does not stall; the
// bound is the state feedback through the products and the drive saturation.
// When the receiver holds out_stall, the drive value stays put and the input
// register takes one more sample if it is empty; once it is full, in_stall rises.
// Setpoint, gains and mode are written through the cfg port (always ready);
// the user must write them only while the block is idle, as the block itself
// does not enforce this. Reset clears the configuration, the integral, the
// error history and the drive accumulator, and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module pid_positional_incremental
    import pidpi_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [MEAS_W-1:0] measurement,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DRIVE_W-1:0]     drive,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t cfg;

    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic signed [MEAS_W-1:0] meas_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     advance;
    logic                     in_xfer;
    logic                     step;

    // The output register can take a new value when it is empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The sample register needs no reset; its valid bit guards it.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            meas_reg <= measurement;
        end
    end

    pidpi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidpi_core #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .meas  (meas_reg),
        .cfg   (cfg),
        .drive (drive)
    );

    `ASSERT_PROP(a_stall_only_when_full, clk, rst_n,
        in_stall |-> in_valid_reg)
    `ASSERT_PROP(a_step_gives_result, clk, rst_n,
        step |=> out_valid_reg)
    `ASSERT_PROP(a_held_sample_kept, clk, rst_n,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(meas_reg)))

endmodule

`default_nettype wire

>>> bench/pid_drive_checker.sv
// Checker for the PID block: predicts each drive value and compares output transfers.
module pid_drive_checker
    import pidpi_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic signed [MEAS_W-1:0] measurement,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [DRIVE_W-1:0] drive,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int SUM_W = 14;
    localparam int ERR_W = MEAS_W + 1;
    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

    cfg_t                       regs;
    logic signed [SUM_W-1:0]    error_sum;
    logic signed [ERR_W-1:0]    last_error;
    logic signed [ERR_W-1:0]    older_error;
    logic signed [DRIVE_W-1:0]  drive_acc;
    logic signed [DRIVE_W-1:0]  pending_drives[$];
    logic signed [DRIVE_W-1:0]  wanted;
    int                         errors = 0;
    int                         drive_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // One control tick: updates the controller state and returns the new drive.
    function automatic logic signed [DRIVE_W-1:0] tick_drive(
        input logic signed [MEAS_W-1:0] meas);
        longint err;
        longint prev;
        longint integ;
        longint weighted;
        longint next;
        longint kp;
        longint ki;
        longint kd;
        kp   = longint'($signed(regs.gain_p));
        ki   = longint'($signed(regs.gain_i));
        kd   = longint'($signed(regs.gain_d));
        err  = longint'($signed(regs.setpoint)) - longint'(meas);
        prev = longint'(last_error);
        if (!regs.incremental_mode)
        begin
            integ = longint'(error_sum) + err;
            if (integ > INTEGRAL_LIMIT)
                integ = INTEGRAL_LIMIT;
            else if (integ < -INTEGRAL_LIMIT)
                integ = -INTEGRAL_LIMIT;
            error_sum = integ[SUM_W-1:0];
            weighted = kp * err + ki * integ + kd * (err - prev);
            next = weighted >>> FRAC_BITS;
        end
        else
        begin
            weighted = kp * (err - prev) + ki * err
                     + kd * (err - 2 * prev + longint'(older_error));
            next = longint'(drive_acc) + (weighted >>> FRAC_BITS);
            older_error = last_error;
        end
        if (next > DRIVE_MAX)
            next = DRIVE_MAX;
        else if (next < DRIVE_MIN)
            next = DRIVE_MIN;
        last_error = err[ERR_W-1:0];
        drive_acc  = next[DRIVE_W-1:0];
        return drive_acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs        = '0;
            error_sum   = '0;
            last_error  = '0;
            older_error = '0;
            drive_acc   = '0;
            pending_drives.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SETPOINT: regs.setpoint = cfg_data;
                    CFG_GAIN_P:   regs.gain_p = cfg_data;
                    CFG_GAIN_I:   regs.gain_i = cfg_data;
                    CFG_GAIN_D:   regs.gain_d = cfg_data;
                    CFG_MODE:     regs.incremental_mode = cfg_data[0];
                    default:      ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_drives.size() == 0)
                    report_mismatch($sformatf("drive %0d with no sample outstanding", drive));
                else
                begin
                    wanted = pending_drives.pop_front();
                    if (drive !== wanted)
                        report_mismatch($sformatf("drive #%0d is %0d, expected %0d",
                                                  drive_count, drive, wanted));
                end
                drive_count++;
            end
            if (in_valid && !in_stall)
                pending_drives.push_back(tick_drive(measurement));
            outstanding <= pending_drives.size();
            mismatches  <= errors;
        end
    end

endmodule

>>> bench/pid_positional_incremental_test.sv
// Testbench top for the PID block: clock, reset, stimulus, idling and the verdict.
module pid_positional_incremental_test;
    import pidpi_pkg::*;

    // Percent of cycles the receiver stalls and of samples the sender pauses before.
    localparam int IDLE_PCT = 7;
    // Cycles without any transfer before the run is declared hung. In a correct
    // run, quiet stretches come only from the random gaps the sender leaves before
    // a sample, the short random runs of receiver stalls and the settle wait
    // between phases, so this is a very wide margin.
    localparam int QUIET_LIMIT = 1000;
    // Samples in a saturation ramp; the integral term alone moves the drive by
    // about 2^23 per tick at full gain, so this comfortably reaches the rail.
    localparam int RAMP_ITEMS = 300;
    // Samples in the random phases, on top of the directed part and the ramps.
    localparam int RANDOM_ITEMS = 800;

    localparam logic POSITIONAL  = 1'b0;
    localparam logic INCREMENTAL = 1'b1;

    localparam logic signed [MEAS_W-1:0] MEAS_MIN = {1'b1, {(MEAS_W - 1){1'b0}}};
    localparam logic signed [MEAS_W-1:0] MEAS_MAX = {1'b0, {(MEAS_W - 1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W - 1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS_DEF);

    // Every input of the block holds a known value from time zero.
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic signed [MEAS_W-1:0]  measurement = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = CFG_SETPOINT;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    wire                       in_stall;
    wire                       out_valid;
    wire                       cfg_ready;
    wire signed [DRIVE_W-1:0]  drive;

    int                        mismatches;
    int                        outstanding;
    int                        quiet_cycles = 0;

    // While set, neither side idles: this gives one long stretch at full rate.
    logic                      calm = 1'b0;

    pid_positional_incremental #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT_DEF),
        .FRAC_BITS      (FRAC_BITS_DEF)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // The checker watches all three channels, keeps its own copy of the
    // controller and hands back the mismatch count and the number of drive
    // values still owed by the block.
    pid_drive_checker #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT_DEF),
        .FRAC_BITS      (FRAC_BITS_DEF)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random, drawn anew each clock, except in the calm stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One sample transfer, sometimes preceded by a short gap with valid low.
    // The payload is held until the block takes it.
    task automatic send_sample(input logic signed [MEAS_W-1:0] value);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Waits until every drive value owed has come back, so that the block is
    // idle before the registers are touched. The first edge is taken before
    // looking at the count, since the count seen at an edge does not yet include
    // a transfer made at that same edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write. Valid is left high so that writes can follow back to
    // back; the caller lowers it when the batch is done.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes to every index past the last register; the block must ignore them.
    task automatic poke_unused_regs();
        for (int k = int'(CFG_MODE) + 1; k < (1 << CFG_INDEX_W); k++)
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
    endtask

    // Writes the whole register set. Now and then a write to an unused index is
    // slipped in, and the mode word carries random upper bits that must not matter.
    task automatic configure(input logic signed [MEAS_W-1:0] sp,
                             input logic signed [GAIN_W-1:0] kp,
                             input logic signed [GAIN_W-1:0] ki,
                             input logic signed [GAIN_W-1:0] kd,
                             input logic                     mode);
        logic [CFG_INDEX_W-1:0] stray;
        stray = CFG_INDEX_W'($urandom_range(int'(CFG_MODE) + 1, (1 << CFG_INDEX_W) - 1));
        write_reg(CFG_SETPOINT, sp);
        if ($urandom_range(99) < 30)
            write_reg(stray, CFG_DATA_W'($urandom));
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_MODE, {(CFG_DATA_W - 1)'($urandom), mode});
        cfg_valid <= 1'b0;
    endtask

    // Gains lean toward the rails, zero and values within plus or minus unity.
    function automatic logic signed [GAIN_W-1:0] rand_gain();
        case ($urandom_range(7))
            0:       return GAIN_MIN;
            1:       return GAIN_MAX;
            2:       return '0;
            3:       return GAIN_W'($urandom_range(0, 2 * int'(GAIN_ONE))) - GAIN_ONE;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Samples lean toward the rails and toward the setpoint, where the error is small.
    function automatic logic signed [MEAS_W-1:0] rand_meas(input logic signed [MEAS_W-1:0] sp);
        case ($urandom_range(9))
            0:       return MEAS_MIN;
            1:       return MEAS_MAX;
            2, 3:    return sp + MEAS_W'($urandom_range(0, 64)) - MEAS_W'(32);
            default: return MEAS_W'($urandom);
        endcase
    endfunction

    // Drives the accumulator toward one rail in incremental mode. A positional
    // tick first replaces the accumulator with a value that does not build on
    // the old drive, so no reset is needed between the two ramps.
    task automatic ramp(input logic rising);
        settle();
        configure(rand_meas('0), rand_gain(), rand_gain(), rand_gain(), POSITIONAL);
        send_sample(rand_meas('0));
        settle();
        configure(rising ? MEAS_MAX : MEAS_MIN, rand_gain(), GAIN_MAX, rand_gain(), INCREMENTAL);
        repeat (RAMP_ITEMS)
        begin
            if (rising)
                send_sample(MEAS_MIN + MEAS_W'($urandom_range(0, 255)));
            else
                send_sample(MEAS_MAX - MEAS_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int                        sent;
        int                        len;
        logic signed [MEAS_W-1:0]  sp;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic                      mode;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset every register is zero, so the drive must stay at zero.
        send_sample(MEAS_MAX);
        send_sample(MEAS_MIN);

        // Largest positive error with all gains at the top: the integral hits
        // its upper clamp at once, then the error drops to zero and the
        // derivative swings the other way.
        settle();
        configure(MEAS_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, POSITIONAL);
        send_sample(MEAS_MIN);
        send_sample(MEAS_MIN);
        send_sample(MEAS_MAX);
        send_sample('0);

        // Largest negative error with all gains at the bottom: lower clamp.
        settle();
        configure(MEAS_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, POSITIONAL);
        send_sample(MEAS_MAX);
        send_sample(MEAS_MAX);
        send_sample(MEAS_MIN);
        send_sample(MEAS_W'(1));

        // Incremental form at unity gains, starting from the drive that the
        // positional form left behind.
        settle();
        configure('0, GAIN_ONE, GAIN_ONE, GAIN_ONE, INCREMENTAL);
        send_sample(MEAS_MIN);
        send_sample(MEAS_MAX);
        send_sample('0);
        send_sample(-MEAS_W'(1));

        // Back to positional with everything else unchanged: the integral and
        // the error history carry over across the mode switch.
        settle();
        configure('0, GAIN_ONE, GAIN_ONE, GAIN_ONE, POSITIONAL);
        send_sample(MEAS_W'(100));
        send_sample(-MEAS_W'(100));

        // Writes to unused indexes must change nothing. Small negative gains
        // check that the fraction shift rounds toward minus infinity.
        settle();
        poke_unused_regs();
        configure(MEAS_W'(123), -GAIN_W'(1), GAIN_W'(1), -GAIN_ONE, INCREMENTAL);
        send_sample(-MEAS_W'(1));
        send_sample('0);
        send_sample(MEAS_W'(200));
        send_sample(MEAS_MIN);

        // Upper rail at full rate, with no idling on either side.
        calm = 1'b1;
        ramp(1'b1);
        settle();
        calm = 1'b0;

        // Random phases: fresh settings most of the time, sometimes only a mode flip.
        sp   = '0;
        kp   = '0;
        ki   = '0;
        kd   = '0;
        mode = POSITIONAL;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == RANDOM_ITEMS / 2)
                ramp(1'b0);
            settle();
            if ($urandom_range(4) == 0)
                mode = !mode;
            else
            begin
                sp   = rand_meas('0);
                kp   = rand_gain();
                ki   = rand_gain();
                kd   = rand_gain();
                mode = $urandom_range(1);
            end
            configure(sp, kp, ki, kd, mode);
            len = $urandom_range(10, 80);
            if (sent < RANDOM_ITEMS / 2 && sent + len > RANDOM_ITEMS / 2)
                len = RANDOM_ITEMS / 2 - sent;
            repeat (len)
                send_sample(rand_meas(sp));
            sent += len;
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> pid_positional_incremental.f
+incdir+rtl
rtl/pidpi_pkg.sv
rtl/pidpi_cfg.sv
rtl/pidpi_core.sv
rtl/pid_positional_incremental.sv
bench/pid_drive_checker.sv
bench/pid_positional_incremental_test.sv
